@@ hdl/escaped_path_pattern_validator_assert.svh @@
// Assertion macros for the escaped path pattern validator.
// Expects clk and rst_n in the scope of every use; empty when SYNTH is set.
`ifndef ESCAPED_PATH_PATTERN_VALIDATOR_ASSERT_SVH
`define ESCAPED_PATH_PATTERN_VALIDATOR_ASSERT_SVH

`ifndef SYNTH
`define EPV_ASSERT_HOLDS(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("epv assertion failed");
`define EPV_ASSERT_NEXT(label, cause, effect) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
    else $error("epv assertion failed");
`else
`define EPV_ASSERT_HOLDS(label, prop)
`define EPV_ASSERT_NEXT(label, cause, effect)
`endif

`endif

@@ hdl/epv_pkg.sv @@
// Shared types, constants and helper functions of the path pattern validator.
// No dependencies; imported by every module of the block.
`default_nettype none

package epv_pkg;

  // Register map indexes (byte address is 4 * index)
  localparam logic [1:0] REG_START_RULE   = 2'd0;
  localparam logic [1:0] REG_PATTERN_RULE = 2'd1;
  localparam logic [1:0] REG_END_RULE     = 2'd2;

  // Rule codes, two's complement: 1 = must, -1 = must not, 0 or -2 = either
  localparam logic [1:0] RULE_MUST     = 2'b01;
  localparam logic [1:0] RULE_MUST_NOT = 2'b11;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_THREE  = 8'h33;
  localparam logic [7:0] CH_SEVEN  = 8'h37;

  typedef enum logic [3:0] {
    ESC_TEXT = 4'b0001,  // plain text
    ESC_OPEN = 4'b0010,  // after a backslash
    ESC_OCT1 = 4'b0100,  // after the first octal digit
    ESC_OCT2 = 4'b1000   // after the second octal digit
  } epv_esc_t;

  typedef struct packed {
    logic [1:0] start_rule;
    logic [1:0] pattern_rule;
    logic [1:0] end_rule;
  } epv_cfg_t;

  typedef struct packed {
    logic saw_pattern;
    logic path_ok;
  } epv_res_t;

  function automatic logic rule_fails(input logic [1:0] rule, input logic [7:0] c);
    rule_fails = ((rule == RULE_MUST) && (c != CH_SLASH)) ||
                 ((rule == RULE_MUST_NOT) && (c == CH_SLASH));
  endfunction

  function automatic logic is_wildcard(input logic [7:0] c);
    is_wildcard = c inside {CH_DOLLAR, 8'h2B, 8'h3F, 8'h2A, 8'h40,
                            8'h78, 8'h58, 8'h61, 8'h41, CH_MINUS};
  endfunction

endpackage

`default_nettype wire

@@ hdl/escaped_path_pattern_validator.sv @@
// Top level of the escaped path pattern validator: stream ports, input and
// result registers. Depends on epv_pkg, epv_regs, epv_step and the assertion header.
`default_nettype none

// Validates one zero-terminated path string at a time, one byte per transfer on
// the in_ channel. Only the zero byte produces a result transfer on out_, carrying
// path_ok and saw_pattern for the string just ended; every other byte is consumed
// silently. The block takes one byte per clock while in_tready is high: a byte is
// registered, checked against the per-string state in the next cycle, and a
// terminator's verdict goes to the out_ register. in_tready drops only while a
// terminator waits in the input register behind a verdict not yet taken on out_.
// Rules are set through the APB port: start_rule at 0x0, pattern_rule at 0x4,
// end_rule at 0x8, each a 2-bit signed value in pwdata[1:0]; write them only
// while no string is in flight.
module escaped_path_pattern_validator (
  input  wire         clk,
  input  wire         rst_n,
  // in_tdata: [7:0] char_code
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,
  // out_tdata: [0] path_ok, [1] saw_pattern, [7:2] zero
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [3:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import epv_pkg::*;

  epv_cfg_t   cfg;
  epv_res_t   res;
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_char_r;
  logic       out_valid_r, out_valid_nxt;
  epv_res_t   out_res_r;
  logic       is_term;
  logic       out_free;
  logic       advance;
  logic       out_load;

  epv_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  epv_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .char_code (in_char_r),
    .cfg       (cfg),
    .res       (res)
  );

  assign is_term   = (in_char_r == CH_NUL);
  assign out_free  = !out_valid_r || out_tready;
  // Plain bytes never wait; a terminator waits for room in the result register
  assign advance   = in_valid_r && (!is_term || out_free);
  assign out_load  = advance && is_term;
  assign in_tready = !in_valid_r || advance;

  assign in_valid_nxt  = in_tready ? in_tvalid : in_valid_r;
  assign out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_char_r <= in_tdata;
    end
    if (out_load) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_res_r.saw_pattern, out_res_r.path_ok};

`include "escaped_path_pattern_validator_assert.svh"

  `EPV_ASSERT_NEXT(a_in_hold, in_valid_r && !advance, in_valid_r && $stable(in_char_r))
  `EPV_ASSERT_HOLDS(a_load_needs_room, !out_load || out_free)
  `EPV_ASSERT_NEXT(a_verdict_from_term, out_load, out_tvalid)

endmodule

`default_nettype wire

@@ hdl/epv_regs.sv @@
// Configuration register file with an APB-style slave port.
// Depends on epv_pkg for the register map and the rule bundle type.
`default_nettype none

module epv_regs (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              psel,
  input  wire              penable,
  input  wire              pwrite,
  input  wire  [3:0]       paddr,
  input  wire  [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output epv_pkg::epv_cfg_t cfg
);
  import epv_pkg::*;

  epv_cfg_t cfg_r;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_START_RULE:   cfg_r.start_rule   <= pwdata[1:0];
        REG_PATTERN_RULE: cfg_r.pattern_rule <= pwdata[1:0];
        REG_END_RULE:     cfg_r.end_rule     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Read back sign-extended
  always_comb begin
    case (paddr[3:2])
      REG_START_RULE:   prdata = {{30{cfg_r.start_rule[1]}}, cfg_r.start_rule};
      REG_PATTERN_RULE: prdata = {{30{cfg_r.pattern_rule[1]}}, cfg_r.pattern_rule};
      REG_END_RULE:     prdata = {{30{cfg_r.end_rule[1]}}, cfg_r.end_rule};
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/epv_step.sv @@
// Per-byte checker: holds the string state and evaluates one byte per cycle while step_en is high.
// Depends on epv_pkg and the assertion macro header.
`default_nettype none

module epv_step (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               step_en,
  input  wire  [7:0]        char_code,
  input  epv_pkg::epv_cfg_t cfg,
  output epv_pkg::epv_res_t res
);
  import epv_pkg::*;

  epv_esc_t   phase_r, phase_nxt;
  logic [1:0] oct_high_r, oct_high_nxt;
  logic [2:0] oct_mid_r, oct_mid_nxt;
  logic [7:0] prev_r, prev_nxt;
  logic [7:0] before_esc_r, before_esc_nxt;
  logic       at_start_r, at_start_nxt;
  logic       esc_start_r, esc_start_nxt;
  logic       in_rep_r, in_rep_nxt;
  logic       pattern_r, pattern_nxt;
  logic       slash_exp_r, slash_exp_nxt;
  logic       err_r, err_nxt;
  logic       ok;
  logic       pass;
  logic [7:0] oct_val;

  assign oct_val = {oct_high_r, oct_mid_r, char_code[2:0]};

  always_comb begin
    phase_nxt      = phase_r;
    oct_high_nxt   = oct_high_r;
    oct_mid_nxt    = oct_mid_r;
    prev_nxt       = prev_r;
    before_esc_nxt = before_esc_r;
    at_start_nxt   = at_start_r;
    esc_start_nxt  = esc_start_r;
    in_rep_nxt     = in_rep_r;
    pattern_nxt    = pattern_r;
    slash_exp_nxt  = slash_exp_r;
    err_nxt        = err_r;
    ok             = 1'b1;

    // Verdict for a terminator arriving now; the empty string counts as NUL first
    pass = !err_r && (phase_r == ESC_TEXT) && !slash_exp_r && !in_rep_r &&
           !(at_start_r && rule_fails(cfg.start_rule, CH_NUL)) &&
           !rule_fails(cfg.end_rule, prev_r) &&
           !((cfg.pattern_rule == RULE_MUST) && !pattern_r);
    res.path_ok     = pass;
    res.saw_pattern = pass && pattern_r;

    if (char_code == CH_NUL) begin
      // Start a fresh string
      phase_nxt      = ESC_TEXT;
      oct_high_nxt   = '0;
      oct_mid_nxt    = '0;
      prev_nxt       = '0;
      before_esc_nxt = '0;
      at_start_nxt   = 1'b1;
      esc_start_nxt  = 1'b0;
      in_rep_nxt     = 1'b0;
      pattern_nxt    = 1'b0;
      slash_exp_nxt  = 1'b0;
      err_nxt        = 1'b0;
    end else begin
      at_start_nxt = 1'b0;
      prev_nxt     = char_code;
      if (!err_r) begin
        if (at_start_r && rule_fails(cfg.start_rule, char_code)) begin
          ok = 1'b0;
        end
        if (ok && slash_exp_r) begin
          slash_exp_nxt = 1'b0;
          if (char_code != CH_SLASH) begin
            ok = 1'b0;
          end
        end
        if (ok) begin
          case (phase_r)
            ESC_TEXT: begin
              if (char_code == CH_BSLASH) begin
                before_esc_nxt = prev_r;
                esc_start_nxt  = at_start_r;
                phase_nxt      = ESC_OPEN;
              end else if (in_rep_r && (char_code == CH_SLASH)) begin
                ok = 1'b0;
              end else if ((char_code <= CH_SPACE) || (char_code >= CH_DEL)) begin
                ok = 1'b0;
              end
            end
            ESC_OPEN: begin
              phase_nxt = ESC_TEXT;
              if (char_code == CH_BSLASH) begin
                ok = 1'b1;
              end else if (is_wildcard(char_code)) begin
                if (cfg.pattern_rule == RULE_MUST_NOT) begin
                  ok = 1'b0;
                end else begin
                  pattern_nxt = 1'b1;
                end
              end else if (char_code == CH_LBRACE) begin
                // Repetition opens only right after a slash, not at string start, and not when patterns are forbidden
                if (esc_start_r || (before_esc_r != CH_SLASH) ||
                    (cfg.pattern_rule == RULE_MUST_NOT)) begin
                  ok = 1'b0;
                end else begin
                  pattern_nxt = 1'b1;
                  in_rep_nxt  = 1'b1;
                end
              end else if (char_code == CH_RBRACE) begin
                if (!in_rep_r) begin
                  ok = 1'b0;
                end else begin
                  in_rep_nxt    = 1'b0;
                  slash_exp_nxt = 1'b1;
                end
              end else if (char_code inside {[CH_ZERO:CH_THREE]}) begin
                oct_high_nxt = char_code[1:0];
                phase_nxt    = ESC_OCT1;
              end else begin
                ok = 1'b0;
              end
            end
            ESC_OCT1: begin
              if (char_code inside {[CH_ZERO:CH_SEVEN]}) begin
                oct_mid_nxt = char_code[2:0];
                phase_nxt   = ESC_OCT2;
              end else begin
                ok = 1'b0;
              end
            end
            default: begin
              phase_nxt = ESC_TEXT;
              if (char_code inside {[CH_ZERO:CH_SEVEN]}) begin
                ok = (oct_val != CH_NUL) && ((oct_val <= CH_SPACE) || (oct_val >= CH_DEL));
              end else begin
                ok = 1'b0;
              end
            end
          endcase
        end
        err_nxt = !ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ESC_TEXT;
      oct_high_r   <= '0;
      oct_mid_r    <= '0;
      prev_r       <= '0;
      before_esc_r <= '0;
      at_start_r   <= 1'b1;
      esc_start_r  <= 1'b0;
      in_rep_r     <= 1'b0;
      pattern_r    <= 1'b0;
      slash_exp_r  <= 1'b0;
      err_r        <= 1'b0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      oct_high_r   <= oct_high_nxt;
      oct_mid_r    <= oct_mid_nxt;
      prev_r       <= prev_nxt;
      before_esc_r <= before_esc_nxt;
      at_start_r   <= at_start_nxt;
      esc_start_r  <= esc_start_nxt;
      in_rep_r     <= in_rep_nxt;
      pattern_r    <= pattern_nxt;
      slash_exp_r  <= slash_exp_nxt;
      err_r        <= err_nxt;
    end
  end

`include "escaped_path_pattern_validator_assert.svh"

  `EPV_ASSERT_NEXT(a_err_sticks, step_en && err_r && (char_code != CH_NUL), err_r)
  `EPV_ASSERT_NEXT(a_term_clears, step_en && (char_code == CH_NUL), at_start_r && !err_r && !in_rep_r && (phase_r == ESC_TEXT))
  `EPV_ASSERT_HOLDS(a_pattern_only_if_ok, !res.saw_pattern || res.path_ok)

endmodule

`default_nettype wire
